>>> hdl/pswb_pkg.sv
// Shared types, constants and helpers for the particle step / wall bounce unit.
package pswb_pkg;

  // Number formats
  localparam int FRAC_BITS = 32;           // fraction bits of positions and velocities
  localparam int DATA_W    = 48;           // position / velocity width
  localparam int PIX_W     = 16;           // wall coordinates, integer pixels
  localparam int DIAM_W    = 47;           // circle diameter register
  localparam int LIM_W     = 47;           // speed limit register
  localparam int COEF_W    = 32;           // damping and pull coefficients
  localparam int CFG_W     = 47;           // config write data, widest register
  localparam int CFG_IDX_W = 3;

  // Internal working width: walls scaled by FRAC_BITS plus headroom for sums
  localparam int BASE_W = (FRAC_BITS + PIX_W > DATA_W) ? FRAC_BITS + PIX_W : DATA_W;
  localparam int WIDE   = BASE_W + 4;

  // Product split: partial products stay at or below 32 x 32
  localparam int SPLIT      = 32;
  localparam int PULL_SHIFT = 32;          // Q0.32 coefficient
  localparam int DAMP_SHIFT = 31;          // Q1.31 coefficient

  // Screen geometry, center of attraction
  localparam int SCREEN_W_PIX = 2300;
  localparam int SCREEN_H_PIX = 1300;
  localparam int CENTER_X_PIX = SCREEN_W_PIX / 2;
  localparam int CENTER_Y_PIX = SCREEN_H_PIX / 2;
  localparam logic signed [WIDE-1:0] CENTER_X_FX = $signed(WIDE'(CENTER_X_PIX) << FRAC_BITS);
  localparam logic signed [WIDE-1:0] CENTER_Y_FX = $signed(WIDE'(CENTER_Y_PIX) << FRAC_BITS);

  // Pipeline depth from accept to result strobe
  localparam int PIPE_DEPTH = 8;

  // Saturation bounds
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Register reset values
  localparam logic [DIAM_W-1:0] DIAM_RST    = '0;
  localparam logic [LIM_W-1:0]  LIM_RST     = '0;
  localparam logic [COEF_W-1:0] DAMP_RST    = 32'd2145336164;   // about 0.999
  localparam logic [COEF_W-1:0] PULL_RST    = 32'd42950;        // about 0.00001
  localparam logic              PULL_EN_RST = 1'b1;
  localparam logic [PIX_W-1:0]  WALL_RST    = '0;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIAMETER    = 3'd0,
    CFG_SPEED_LIMIT = 3'd1,
    CFG_DAMPING     = 3'd2,
    CFG_PULL        = 3'd3,
    CFG_PULL_EN     = 3'd4,
    CFG_WALL_RIGHT  = 3'd5,
    CFG_WALL_BOTTOM = 3'd6
  } cfg_idx_e;

  // Input item
  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [DATA_W-1:0] new_pos_x;
    logic signed [DATA_W-1:0] new_pos_y;
    logic signed [DATA_W-1:0] new_vel_x;
    logic signed [DATA_W-1:0] new_vel_y;
  } out_item_t;

  // Per-axis settings; the user must keep them static while items are in flight, the block does not enforce it
  typedef struct packed {
    logic        [DIAM_W-2:0] half;
    logic signed [WIDE-1:0]   wall;
    logic signed [WIDE-1:0]   wall_minus_half;
    logic signed [WIDE-1:0]   center;
    logic        [LIM_W-1:0]  lim;
    logic        [COEF_W-1:0] damp;
    logic        [COEF_W-1:0] pull;
    logic                     pull_en;
  } axis_cfg_t;

  // Clip a working-width value to the data range
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE-1:0] x);
    logic signed [WIDE-1:0] hi;
    logic signed [WIDE-1:0] lo;
    hi = WIDE'(DATA_MAX);
    lo = WIDE'(DATA_MIN);
    if (x > hi) begin
      return DATA_MAX;
    end else if (x < lo) begin
      return DATA_MIN;
    end else begin
      return DATA_W'(x);
    end
  endfunction

endpackage

>>> hdl/pswb_axis.sv
// One axis of the motion step: pull, speed clamp, wall bounce, position update; in clamp mode, a position clamp.
module pswb_axis (
  input  logic                               clk_i,
  input  pswb_pkg::axis_cfg_t                cfg_i,
  input  logic                               func_i,
  input  logic signed [pswb_pkg::DATA_W-1:0] pos_i,
  input  logic signed [pswb_pkg::DATA_W-1:0] vel_i,
  output logic signed [pswb_pkg::DATA_W-1:0] new_pos_o,
  output logic signed [pswb_pkg::DATA_W-1:0] new_vel_o
);
  import pswb_pkg::*;

  localparam int MAG_W  = WIDE - 1;          // |pos - center|
  localparam int LO_W   = 2 * SPLIT;         // low partial products
  localparam int VMAG_W = DATA_W - 1;        // |clamped velocity|
  localparam int V1_W   = WIDE + 1;          // pulled velocity before clamp

  // Settings at working width
  logic signed [WIDE-1:0] half_w;
  logic signed [V1_W-1:0] lim_v1;
  assign half_w = $signed(WIDE'(cfg_i.half));
  assign lim_v1 = $signed(V1_W'(cfg_i.lim));

  // ---------------- stage 1: distance to center ----------------
  logic signed [WIDE-1:0]   ctr_off;
  logic                     s1_neg_d, s1_neg_q;
  logic [MAG_W-1:0]         s1_mag_d, s1_mag_q;
  logic signed [DATA_W-1:0] s1_pos_q, s1_vel_q;
  logic                     s1_func_q;

  always_comb begin
    ctr_off  = WIDE'(pos_i) - cfg_i.center;
    s1_neg_d = ctr_off[WIDE-1];
    s1_mag_d = s1_neg_d ? MAG_W'(-ctr_off) : MAG_W'(ctr_off);
  end

  always_ff @(posedge clk_i) begin
    s1_neg_q  <= s1_neg_d;
    s1_mag_q  <= s1_mag_d;
    s1_pos_q  <= pos_i;
    s1_vel_q  <= vel_i;
    s1_func_q <= func_i;
  end

  // ---------------- stage 2: pull partial products ----------------
  logic [MAG_W-1:0]         s2_pp_hi_d, s2_pp_hi_q;
  logic [LO_W-1:0]          s2_pp_lo_d, s2_pp_lo_q;
  logic                     s2_neg_q;
  logic signed [DATA_W-1:0] s2_pos_q, s2_vel_q;
  logic                     s2_func_q;

  always_comb begin
    s2_pp_hi_d = MAG_W'(s1_mag_q[MAG_W-1:SPLIT]) * MAG_W'(cfg_i.pull);
    s2_pp_lo_d = LO_W'(s1_mag_q[SPLIT-1:0]) * LO_W'(cfg_i.pull);
  end

  always_ff @(posedge clk_i) begin
    s2_pp_hi_q <= s2_pp_hi_d;
    s2_pp_lo_q <= s2_pp_lo_d;
    s2_neg_q   <= s1_neg_q;
    s2_pos_q   <= s1_pos_q;
    s2_vel_q   <= s1_vel_q;
    s2_func_q  <= s1_func_q;
  end

  // ---------------- stage 3: pull magnitude, position +- half ----------------
  logic [MAG_W-1:0]         s3_pm_d, s3_pm_q;
  logic signed [WIDE-1:0]   s3_pph_d, s3_pph_q;
  logic signed [WIDE-1:0]   s3_pmh_d, s3_pmh_q;
  logic                     s3_neg_q;
  logic signed [DATA_W-1:0] s3_pos_q, s3_vel_q;
  logic                     s3_func_q;

  // product magnitude truncated; fits since the coefficient is below one
  always_comb begin
    s3_pm_d  = (s2_pp_hi_q << (SPLIT - PULL_SHIFT)) + MAG_W'(s2_pp_lo_q >> PULL_SHIFT);
    s3_pph_d = WIDE'(s2_pos_q) + half_w;
    s3_pmh_d = WIDE'(s2_pos_q) - half_w;
  end

  always_ff @(posedge clk_i) begin
    s3_pm_q   <= s3_pm_d;
    s3_pph_q  <= s3_pph_d;
    s3_pmh_q  <= s3_pmh_d;
    s3_neg_q  <= s2_neg_q;
    s3_pos_q  <= s2_pos_q;
    s3_vel_q  <= s2_vel_q;
    s3_func_q <= s2_func_q;
  end

  // ---------------- stage 4: apply pull, clamp speed, clamp position ----------------
  logic signed [V1_W-1:0]   v1;
  logic signed [V1_W-1:0]   pm_v1;
  logic signed [DATA_W-1:0] s4_vc_d, s4_vc_q;
  logic signed [WIDE-1:0]   s4_pclamp_d, s4_pclamp_q;
  logic signed [WIDE-1:0]   s4_pph_q, s4_pmh_q;
  logic signed [DATA_W-1:0] s4_pos_q, s4_vel_q;
  logic                     s4_func_q;

  always_comb begin
    pm_v1 = $signed(V1_W'(s3_pm_q));
    v1    = V1_W'(s3_vel_q);
    if (cfg_i.pull_en) begin
      v1 = s3_neg_q ? V1_W'(s3_vel_q) + pm_v1 : V1_W'(s3_vel_q) - pm_v1;
    end
    // |lim| < 2^47, so the clamped value fits the data width
    if (v1 > lim_v1) begin
      s4_vc_d = DATA_W'(lim_v1);
    end else if (v1 < -lim_v1) begin
      s4_vc_d = DATA_W'(-lim_v1);
    end else begin
      s4_vc_d = DATA_W'(v1);
    end
    // clamp-only mode position
    if (s3_pph_q > cfg_i.wall) begin
      s4_pclamp_d = cfg_i.wall_minus_half;
    end else if (s3_pmh_q < 0) begin
      s4_pclamp_d = half_w;
    end else begin
      s4_pclamp_d = WIDE'(s3_pos_q);
    end
  end

  always_ff @(posedge clk_i) begin
    s4_vc_q     <= s4_vc_d;
    s4_pclamp_q <= s4_pclamp_d;
    s4_pph_q    <= s3_pph_q;
    s4_pmh_q    <= s3_pmh_q;
    s4_pos_q    <= s3_pos_q;
    s4_vel_q    <= s3_vel_q;
    s4_func_q   <= s3_func_q;
  end

  // ---------------- stage 5: wall tests ----------------
  logic                     vc_pos, vc_neg, hit_hi, hit_lo;
  logic signed [WIDE-1:0]   vc_w;
  logic signed [WIDE-1:0]   s5_pos_d, s5_pos_q;
  logic [VMAG_W-1:0]        s5_vmag_d, s5_vmag_q;
  logic                     s5_bounce_d, s5_bounce_q;
  logic                     s5_bneg_q;
  logic signed [DATA_W-1:0] s5_vel_d, s5_vel_q;
  logic                     s5_func_q;

  always_comb begin
    vc_w   = WIDE'(s4_vc_q);
    vc_neg = s4_vc_q[DATA_W-1];
    vc_pos = !vc_neg && (s4_vc_q != '0);
    hit_hi = (s4_pph_q + vc_w > cfg_i.wall) && vc_pos;
    hit_lo = (s4_pmh_q + vc_w < 0) && vc_neg;
    if (s4_func_q) begin
      s5_pos_d = s4_pclamp_q;
    end else if (hit_hi) begin
      s5_pos_d = cfg_i.wall_minus_half - vc_w;
    end else if (hit_lo) begin
      s5_pos_d = half_w - vc_w;
    end else begin
      s5_pos_d = WIDE'(s4_pos_q);
    end
    s5_vmag_d   = vc_neg ? VMAG_W'(-s4_vc_q) : VMAG_W'(s4_vc_q);
    s5_bounce_d = !s4_func_q && (hit_hi || hit_lo);
    // clamp mode passes the input velocity through
    s5_vel_d    = s4_func_q ? s4_vel_q : s4_vc_q;
  end

  always_ff @(posedge clk_i) begin
    s5_pos_q    <= s5_pos_d;
    s5_vmag_q   <= s5_vmag_d;
    s5_bounce_q <= s5_bounce_d;
    s5_bneg_q   <= hit_hi;        // reversed velocity is negative off the high wall
    s5_vel_q    <= s5_vel_d;
    s5_func_q   <= s4_func_q;
  end

  // ---------------- stage 6: damping partial products ----------------
  logic [VMAG_W-1:0]        s6_dp_hi_d, s6_dp_hi_q;
  logic [LO_W-1:0]          s6_dp_lo_d, s6_dp_lo_q;
  logic signed [WIDE-1:0]   s6_pos_q;
  logic                     s6_bounce_q, s6_bneg_q;
  logic signed [DATA_W-1:0] s6_vel_q;
  logic                     s6_func_q;

  always_comb begin
    s6_dp_hi_d = VMAG_W'(s5_vmag_q[VMAG_W-1:SPLIT]) * VMAG_W'(cfg_i.damp);
    s6_dp_lo_d = LO_W'(s5_vmag_q[SPLIT-1:0]) * LO_W'(cfg_i.damp);
  end

  always_ff @(posedge clk_i) begin
    s6_dp_hi_q  <= s6_dp_hi_d;
    s6_dp_lo_q  <= s6_dp_lo_d;
    s6_pos_q    <= s5_pos_q;
    s6_bounce_q <= s5_bounce_q;
    s6_bneg_q   <= s5_bneg_q;
    s6_vel_q    <= s5_vel_q;
    s6_func_q   <= s5_func_q;
  end

  // ---------------- stage 7: damped, reversed velocity ----------------
  logic [DATA_W-1:0]        dm;
  logic signed [DATA_W:0]   vb;
  logic signed [DATA_W-1:0] s7_vel_d, s7_vel_q;
  logic signed [WIDE-1:0]   s7_pos_q;
  logic                     s7_func_q;

  always_comb begin
    dm = (DATA_W'(s6_dp_hi_q) << (SPLIT - DAMP_SHIFT)) + DATA_W'(s6_dp_lo_q >> DAMP_SHIFT);
    vb = s6_bneg_q ? -$signed({1'b0, dm}) : $signed({1'b0, dm});
    s7_vel_d = s6_bounce_q ? sat_data(WIDE'(vb)) : s6_vel_q;
  end

  always_ff @(posedge clk_i) begin
    s7_vel_q  <= s7_vel_d;
    s7_pos_q  <= s6_pos_q;
    s7_func_q <= s6_func_q;
  end

  // ---------------- stage 8: position update and saturation ----------------
  logic signed [WIDE-1:0]   pos_sum;
  logic signed [DATA_W-1:0] s8_pos_q, s8_vel_q;

  always_comb begin
    pos_sum = s7_func_q ? s7_pos_q : s7_pos_q + WIDE'(s7_vel_q);
  end

  always_ff @(posedge clk_i) begin
    s8_pos_q <= sat_data(pos_sum);
    s8_vel_q <= s7_vel_q;
  end

  assign new_pos_o = s8_pos_q;
  assign new_vel_o = s8_vel_q;

endmodule

>>> hdl/particle_step_wall_bounce_unit.sv
// Top level: config registers, valid pipeline and the two axis datapaths.
// A result strobes on done_o when its item leaves the last pipeline stage.
// Throughput: one item per cycle; each axis is an 8-stage pipeline with split multiplies.
// busy stays low, so start may be held high every cycle; results cannot be stalled.
// Reset (rst_ni low, asynchronous) drops items in flight and restores register defaults.
module particle_step_wall_bounce_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  pswb_pkg::in_item_t                   item_i,
  output logic                                 done_o,
  output pswb_pkg::out_item_t                  result_o,
  input  logic                                 cfg_we_i,
  input  logic [pswb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pswb_pkg::CFG_W-1:0]           cfg_wdata_i
);
  import pswb_pkg::*;

  // Configuration registers
  logic [DIAM_W-1:0] diam_q;
  logic [LIM_W-1:0]  lim_q;
  logic [COEF_W-1:0] damp_q;
  logic [COEF_W-1:0] pull_q;
  logic              pull_en_q;
  logic [PIX_W-1:0]  wall_r_q;
  logic [PIX_W-1:0]  wall_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diam_q    <= DIAM_RST;
      lim_q     <= LIM_RST;
      damp_q    <= DAMP_RST;
      pull_q    <= PULL_RST;
      pull_en_q <= PULL_EN_RST;
      wall_r_q  <= WALL_RST;
      wall_b_q  <= WALL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DIAMETER:    diam_q    <= cfg_wdata_i[DIAM_W-1:0];
        CFG_SPEED_LIMIT: lim_q     <= cfg_wdata_i[LIM_W-1:0];
        CFG_DAMPING:     damp_q    <= cfg_wdata_i[COEF_W-1:0];
        CFG_PULL:        pull_q    <= cfg_wdata_i[COEF_W-1:0];
        CFG_PULL_EN:     pull_en_q <= cfg_wdata_i[0];
        CFG_WALL_RIGHT:  wall_r_q  <= cfg_wdata_i[PIX_W-1:0];
        CFG_WALL_BOTTOM: wall_b_q  <= cfg_wdata_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-axis settings
  logic [DIAM_W-2:0]      half;
  logic signed [WIDE-1:0] half_w, wall_x, wall_y;
  axis_cfg_t              cfg_x, cfg_y;

  always_comb begin
    half   = diam_q[DIAM_W-1:1];
    half_w = $signed(WIDE'(half));
    wall_x = $signed(WIDE'(wall_r_q) << FRAC_BITS);
    wall_y = $signed(WIDE'(wall_b_q) << FRAC_BITS);

    cfg_x.half            = half;
    cfg_x.wall            = wall_x;
    cfg_x.wall_minus_half = wall_x - half_w;
    cfg_x.center          = CENTER_X_FX;
    cfg_x.lim             = lim_q;
    cfg_x.damp            = damp_q;
    cfg_x.pull            = pull_q;
    cfg_x.pull_en         = pull_en_q;

    cfg_y                 = cfg_x;
    cfg_y.wall            = wall_y;
    cfg_y.wall_minus_half = wall_y - half_w;
    cfg_y.center          = CENTER_Y_FX;
  end

  // Handshake: the pipeline takes an item every cycle
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid bits and mode travel alongside the datapath
  logic [PIPE_DEPTH-1:0] valid_q;
  logic [PIPE_DEPTH-1:0] func_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[PIPE_DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= {func_q[PIPE_DEPTH-2:0], item_i.func};
  end

  assign done_o = valid_q[PIPE_DEPTH-1];

  // Axis datapaths
  pswb_axis u_axis_x (
    .clk_i     (clk_i),
    .cfg_i     (cfg_x),
    .func_i    (item_i.func),
    .pos_i     (item_i.pos_x),
    .vel_i     (item_i.vel_x),
    .new_pos_o (result_o.new_pos_x),
    .new_vel_o (result_o.new_vel_x)
  );

  pswb_axis u_axis_y (
    .clk_i     (clk_i),
    .cfg_i     (cfg_y),
    .func_i    (item_i.func),
    .pos_i     (item_i.pos_y),
    .vel_i     (item_i.vel_y),
    .new_pos_o (result_o.new_pos_y),
    .new_vel_o (result_o.new_vel_y)
  );

  // Checks
  // every result strobe traces back to an accepted item
  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(valid_q[0], PIPE_DEPTH-1))
    else $error("result strobe without an accepted item");

  // clamp mode returns the input velocities untouched
  a_clamp_vel_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && func_q[PIPE_DEPTH-1] |-> result_o.new_vel_x == $past(item_i.vel_x, PIPE_DEPTH))
    else $error("clamp mode changed x velocity");

  a_clamp_vel_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && func_q[PIPE_DEPTH-1] |-> result_o.new_vel_y == $past(item_i.vel_y, PIPE_DEPTH))
    else $error("clamp mode changed y velocity");

endmodule

>>> bench/testbench.sv
// Self-checking bench for the particle step / wall bounce unit: directed table, then random.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pswb_pkg::*;

  // Operation codes carried in the func field
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLAMP = 1'b1;

  // Number format and screen geometry
  localparam int     FRAC  = FRAC_BITS;
  localparam longint MID_X = longint'(2300 / 2) <<< FRAC;
  localparam longint MID_Y = longint'(1300 / 2) <<< FRAC;
  localparam longint Q_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint Q_MIN = -Q_MAX - 1;
  localparam logic [47:0] P_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] P_MIN = 48'h8000_0000_0000;

  // Run shape
  localparam int LATENCY         = PIPE_DEPTH;
  localparam int ITEMS_PER_PHASE = 148;
  localparam int PRINT_CAP       = 40;

  // Register image kept by the predictor
  typedef struct {
    logic [46:0] diameter;
    logic [46:0] speed_cap;
    logic [31:0] damping;
    logic [31:0] pull_gain;
    logic        pull_on;
    logic [15:0] right_px;
    logic [15:0] bottom_px;
  } motion_setup_t;

  // One row of the directed table
  typedef struct {
    int        setup;
    in_item_t  item;
    bit        known;
    out_item_t want;
  } directed_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  in_item_t    item_i      = '0;
  logic        done_o;
  out_item_t   result_o;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = CFG_DIAMETER;
  logic [46:0] cfg_wdata_i = '0;

  motion_setup_t regs_now;
  motion_setup_t fixed_setups[4];
  directed_row_t stimulus_table[$];
  out_item_t     expected_states[$];

  int sent            = 0;
  int directed_count  = 0;
  int step_items      = 0;
  int clamp_items     = 0;
  int bounce_count    = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int setups_loaded   = 0;

  particle_step_wall_bounce_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic longint clip_q(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // a * k / 2^sh, magnitude truncated toward zero, sign put back afterwards
  function automatic longint scaled(input longint a, input logic [31:0] k, input int sh);
    logic [127:0] mag;
    logic [127:0] prod;
    mag  = (a < 0) ? 128'(-a) : 128'(a);
    prod = (mag * {96'd0, k}) >> sh;
    return (a < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // pull toward center, speed cap, wall reflection, then advance
  function automatic void step_one_axis(input longint p0, input longint v0,
                                        input longint ctr, input longint wall,
                                        input longint half,
                                        output longint p1, output longint v1);
    longint p;
    longint v;
    longint cap;
    p   = p0;
    v   = v0;
    cap = longint'(regs_now.speed_cap);
    if (regs_now.pull_on) v = v - scaled(p - ctr, regs_now.pull_gain, 32);
    if (v > cap) v = cap;
    if (v < -cap) v = -cap;
    if (p + half + v > wall && v > 0) begin
      p = wall - half - v;
      v = clip_q(scaled(-v, regs_now.damping, 31));
      bounce_count++;
    end else if (p - half + v < 0 && v < 0) begin
      p = half - v;
      v = clip_q(scaled(-v, regs_now.damping, 31));
      bounce_count++;
    end
    p1 = clip_q(p + v);
    v1 = v;
  endfunction

  function automatic longint clamp_one_axis(input longint p, input longint wall,
                                            input longint half);
    if (p + half > wall) return clip_q(wall - half);
    else if (p - half < 0) return clip_q(half);
    return clip_q(p);
  endfunction

  function automatic out_item_t advance_particle(input in_item_t it);
    longint    px;
    longint    py;
    longint    vx;
    longint    vy;
    longint    half;
    longint    wx;
    longint    wy;
    out_item_t r;
    px   = longint'(it.pos_x);
    py   = longint'(it.pos_y);
    vx   = longint'(it.vel_x);
    vy   = longint'(it.vel_y);
    half = longint'(regs_now.diameter >> 1);
    wx   = longint'(regs_now.right_px) <<< FRAC;
    wy   = longint'(regs_now.bottom_px) <<< FRAC;
    if (it.func == OP_STEP) begin
      step_one_axis(px, vx, MID_X, wx, half, px, vx);
      step_one_axis(py, vy, MID_Y, wy, half, py, vy);
    end else begin
      px = clamp_one_axis(px, wx, half);
      py = clamp_one_axis(py, wy, half);
    end
    r.new_pos_x = px[47:0];
    r.new_pos_y = py[47:0];
    r.new_vel_x = vx[47:0];
    r.new_vel_y = vy[47:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [47:0] pix(input int n);
    return 48'(longint'(n) <<< FRAC);
  endfunction

  function automatic logic [47:0] rand_bits48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // uniform in [-s, s]
  function automatic longint rand_span(input longint s);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (s <= 0) return 0;
    return longint'(w % 64'(2 * s + 1)) - s;
  endfunction

  // near either wall or anywhere in between
  function automatic logic [47:0] place_on_axis(input longint wall, input longint half,
                                                input longint cap);
    longint reach;
    longint p;
    reach = cap + (longint'(8) <<< FRAC);
    case ($urandom_range(0, 3))
      0: p = half + rand_span(reach);
      1: p = wall - half + rand_span(reach);
      default: p = wall / 2 + rand_span(wall / 2);
    endcase
    return 48'(clip_q(p));
  endfunction

  // mostly particles inside the walls heading somewhere; a quarter raw noise
  function automatic in_item_t rand_particle();
    in_item_t it;
    longint   wx;
    longint   wy;
    longint   half;
    longint   cap;
    wx   = longint'(regs_now.right_px) <<< FRAC;
    wy   = longint'(regs_now.bottom_px) <<< FRAC;
    half = longint'(regs_now.diameter >> 1);
    cap  = longint'(regs_now.speed_cap);
    if ($urandom_range(0, 99) < 25) begin
      it.func  = 1'($urandom_range(0, 1));
      it.pos_x = rand_bits48();
      it.pos_y = rand_bits48();
      it.vel_x = rand_bits48();
      it.vel_y = rand_bits48();
    end else begin
      it.func  = ($urandom_range(0, 99) < 15) ? OP_CLAMP : OP_STEP;
      it.pos_x = place_on_axis(wx, half, cap);
      it.pos_y = place_on_axis(wy, half, cap);
      it.vel_x = 48'(clip_q(rand_span(cap + cap / 2 + 1)));
      it.vel_y = 48'(clip_q(rand_span(cap + cap / 2 + 1)));
    end
    return it;
  endfunction

  function automatic motion_setup_t setup_of(input logic [46:0] diam, input logic [46:0] cap,
                                             input logic [31:0] damp, input logic [31:0] pull,
                                             input logic on, input logic [15:0] right,
                                             input logic [15:0] bottom);
    motion_setup_t s;
    s.diameter  = diam;
    s.speed_cap = cap;
    s.damping   = damp;
    s.pull_gain = pull;
    s.pull_on   = on;
    s.right_px  = right;
    s.bottom_px = bottom;
    return s;
  endfunction

  // mostly screen-like sizes, now and then full-range values
  function automatic motion_setup_t rand_setup();
    motion_setup_t s;
    s.diameter  = ($urandom_range(0, 9) == 0) ? 47'({$urandom, $urandom})
                                              : 47'({$urandom_range(0, 120), $urandom});
    s.speed_cap = ($urandom_range(0, 9) == 0) ? 47'({$urandom, $urandom})
                                              : 47'({$urandom_range(0, 30), $urandom});
    s.damping   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h8000_0000);
    s.pull_gain = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
    s.pull_on   = 1'($urandom_range(0, 1));
    s.right_px  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(50, 4000));
    s.bottom_px = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(50, 4000));
    return s;
  endfunction

  task automatic add_row(input int setup, input logic func,
                         input logic [47:0] px, input logic [47:0] py,
                         input logic [47:0] vx, input logic [47:0] vy,
                         input bit known = 1'b0, input out_item_t want = '0);
    directed_row_t row;
    row.setup      = setup;
    row.item.func  = func;
    row.item.pos_x = px;
    row.item.pos_y = py;
    row.item.vel_x = vx;
    row.item.vel_y = vy;
    row.known      = known;
    row.want       = want;
    stimulus_table.push_back(row);
  endtask

  // ---------------------------------------------------------------- driving

  task automatic write_reg(input cfg_idx_e idx, input logic [46:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // only called with nothing in flight
  task automatic load_setup(input motion_setup_t s);
    write_reg(CFG_DIAMETER, s.diameter);
    write_reg(CFG_SPEED_LIMIT, s.speed_cap);
    write_reg(CFG_DAMPING, 47'(s.damping));
    write_reg(CFG_PULL, 47'(s.pull_gain));
    write_reg(CFG_PULL_EN, 47'(s.pull_on));
    write_reg(CFG_WALL_RIGHT, 47'(s.right_px));
    write_reg(CFG_WALL_BOTTOM, 47'(s.bottom_px));
    cfg_we_i <= 1'b0;
    regs_now = s;
    setups_loaded++;
  endtask

  task automatic send_particle(input in_item_t it, input bit known, input out_item_t want);
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    expected_states.push_back(known ? want : advance_particle(it));
    sent++;
    if (it.func == OP_STEP) step_items++;
    else clamp_items++;
  endtask

  // each cycle idles with the given odds, so about pct cycles of a hundred are idle
  task automatic idle_gap(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_all_landed();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_states.size() > 0);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [47:0] got,
                             input logic [47:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got %h want %h", results_checked, name,
                              got, want));
  endtask

  // results strobe for one cycle; sample the values that held before this edge
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (expected_states.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", result_o));
      end else begin
        want = expected_states.pop_front();
        check_field("new_pos_x", result_o.new_pos_x, want.new_pos_x);
        check_field("new_pos_y", result_o.new_pos_y, want.new_pos_y);
        check_field("new_vel_x", result_o.new_vel_x, want.new_vel_x);
        check_field("new_vel_y", result_o.new_vel_y, want.new_vel_y);
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : stimulus
    int idle_pct;
    int cur;

    // reset values, screen-sized, all-high extremes, zero damping and pull with odd diameter
    fixed_setups[0] = setup_of(47'd0, 47'd0, 32'd2145336164, 32'd42950, 1'b1, 16'd0, 16'd0);
    fixed_setups[1] = setup_of(47'(pix(20)), 47'(pix(8)), 32'd2145336164, 32'd42950, 1'b1,
                               16'd2300, 16'd1300);
    fixed_setups[2] = setup_of('1, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                               16'hFFFF, 16'hFFFF);
    fixed_setups[3] = setup_of(47'd1, '1, 32'd0, 32'd0, 1'b0, 16'd100, 16'd50);
    regs_now = fixed_setups[0];

    // after reset: zero speed cap kills velocity, zero walls pin clamped positions to 0
    add_row(0, OP_STEP, P_MAX, P_MIN, P_MAX, P_MIN, 1'b1,
            out_item_t'{P_MAX, P_MIN, 48'd0, 48'd0});
    add_row(0, OP_STEP, 48'd0, 48'd0, 48'd1, '1, 1'b1,
            out_item_t'{48'd0, 48'd0, 48'd0, 48'd0});
    add_row(0, OP_STEP, pix(1150), pix(650), pix(3), pix(-3), 1'b1,
            out_item_t'{pix(1150), pix(650), 48'd0, 48'd0});
    add_row(0, OP_CLAMP, P_MAX, P_MIN, P_MAX, P_MIN, 1'b1,
            out_item_t'{48'd0, 48'd0, P_MAX, P_MIN});
    add_row(0, OP_CLAMP, '1, 48'd1, 48'd0, 48'(-5), 1'b1,
            out_item_t'{48'd0, 48'd0, 48'd0, 48'(-5)});
    // screen-sized: free flight, each wall, corner, speed cap, clamp both ways
    add_row(1, OP_STEP, pix(1000), pix(600), pix(2), pix(-1));
    add_row(1, OP_STEP, pix(2287), pix(640), pix(5), 48'd0);
    add_row(1, OP_STEP, pix(12), pix(640), pix(-5), 48'd0);
    add_row(1, OP_STEP, pix(1100), pix(1287), 48'd0, pix(5));
    add_row(1, OP_STEP, pix(1100), pix(11), 48'd0, pix(-3));
    add_row(1, OP_STEP, pix(1100), pix(600), pix(100), pix(-100));
    add_row(1, OP_STEP, pix(2295), pix(1295), pix(7), pix(7));
    add_row(1, OP_STEP, pix(700) + 48'd1, pix(300) + 48'h8000_0001, '1, 48'd1);
    add_row(1, OP_CLAMP, pix(2400), pix(1400), pix(3), pix(-3));
    add_row(1, OP_CLAMP, pix(-50), pix(-50), pix(-1), pix(1));
    add_row(1, OP_CLAMP, pix(500), pix(500), pix(4), pix(4));
    // walls past the format range, damping above one, largest pull and diameter
    add_row(2, OP_STEP, P_MAX, P_MAX, P_MAX, P_MAX);
    add_row(2, OP_STEP, P_MIN, P_MIN, P_MIN, P_MIN);
    add_row(2, OP_STEP, 48'd0, 48'd0, P_MIN, P_MAX);
    add_row(2, OP_CLAMP, P_MAX, P_MIN, 48'd0, 48'd0);
    // zero damping, pull off, odd diameter of one tick
    add_row(3, OP_STEP, pix(99), pix(49), pix(3), pix(3));
    add_row(3, OP_STEP, pix(-5), pix(-5), pix(-1), '1);
    add_row(3, OP_CLAMP, pix(101), '1, P_MAX, P_MIN);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    cur = 0;
    foreach (stimulus_table[i]) begin
      if (stimulus_table[i].setup != cur) begin
        wait_all_landed();
        cur = stimulus_table[i].setup;
        load_setup(fixed_setups[cur]);
      end
      send_particle(stimulus_table[i].item, stimulus_table[i].known, stimulus_table[i].want);
      idle_gap(30);
    end
    directed_count = sent;

    // random phases: fixed settings first, then random ones; sender gaps 30%, 59%, none
    for (int phase = 0; phase < 9; phase++) begin
      wait_all_landed();
      load_setup(phase < 4 ? fixed_setups[phase] : rand_setup());
      idle_pct = (phase < 3) ? 30 : (phase < 6) ? 59 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // let the pipe run dry once in the middle of a phase
        if (phase == 4 && n == ITEMS_PER_PHASE / 2) wait_all_landed();
        send_particle(rand_particle(), 1'b0, '0);
        idle_gap(idle_pct);
      end
    end

    // drain, then watch a little longer for stray strobes
    wait_all_landed();
    repeat (LATENCY + 4) @(posedge clk_i);

    $display("covered %0d items (%0d directed; %0d step, %0d clamp), %0d predicted bounces",
             sent, directed_count, step_items, clamp_items, bounce_count);
    $display("%0d register settings loaded, %0d results compared, %0d mismatches",
             setups_loaded, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout: %0d results still pending", expected_states.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> particle_step_wall_bounce_unit.f
hdl/pswb_pkg.sv
hdl/pswb_axis.sv
hdl/particle_step_wall_bounce_unit.sv
bench/testbench.sv
